FILE: hw/rtl/irpfd_pkg.sv
// ----------------------------------------------------------------------------
// irpfd_pkg: shared types and constants of the IR pulse frame decoder
// Timing window defaults, register indexes, frame byte patterns and
// command codes.
// ----------------------------------------------------------------------------
package irpfd_pkg;

	// Frame geometry
	localparam int FRAME_BYTES = 4;
	localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
	localparam int BIT_CNT_W   = 3;

	// Field widths
	localparam int TIME_W = 16;
	localparam int CMD_W  = 3;
	localparam int WRAP_W = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_LOW  = 3'd0,
		REG_START_HIGH = 3'd1,
		REG_ONE_LOW    = 3'd2,
		REG_ONE_HIGH   = 3'd3,
		REG_ZERO_LOW   = 3'd4,
		REG_ZERO_HIGH  = 3'd5
	} cfg_reg_t;

	// Window reset values in timer ticks
	localparam logic [TIME_W-1:0] START_LOW_RST  = 16'd4000;
	localparam logic [TIME_W-1:0] START_HIGH_RST = 16'd5000;
	localparam logic [TIME_W-1:0] ONE_LOW_RST    = 16'd1400;
	localparam logic [TIME_W-1:0] ONE_HIGH_RST   = 16'd1800;
	localparam logic [TIME_W-1:0] ZERO_LOW_RST   = 16'd400;
	localparam logic [TIME_W-1:0] ZERO_HIGH_RST  = 16'd700;

	// Input item kinds
	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_WRAP = 1'b1
	} opcode_t;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_NONE  = 3'd0,
		CMD_FWD   = 3'd1,
		CMD_BACK  = 3'd2,
		CMD_LEFT  = 3'd3,
		CMD_RIGHT = 3'd4,
		CMD_CTR   = 3'd5
	} cmd_t;

	// Address and command byte pairs
	localparam logic [7:0] ADDR_LO     = 8'h00;
	localparam logic [7:0] ADDR_HI     = 8'hFF;
	localparam logic [7:0] PAIR_FWD_A  = 8'h18;
	localparam logic [7:0] PAIR_FWD_B  = 8'hE7;
	localparam logic [7:0] PAIR_BACK_A = 8'h52;
	localparam logic [7:0] PAIR_BACK_B = 8'hAD;
	localparam logic [7:0] PAIR_LEFT_A = 8'h08;
	localparam logic [7:0] PAIR_LEFT_B = 8'hF7;
	localparam logic [7:0] PAIR_RGT_A  = 8'h5A;
	localparam logic [7:0] PAIR_RGT_B  = 8'hA5;
	localparam logic [7:0] PAIR_CTR_A  = 8'h1C;
	localparam logic [7:0] PAIR_CTR_B  = 8'hE3;
	localparam logic [7:0] ONE_BIT_MSB = 8'h80;

endpackage

FILE: hw/rtl/ir_pulse_frame_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder: IR remote pulse timing to command code
// An accepted item goes through the input register and then the result register
// to the master side. Throughput: 1 item per cycle while m_tready keeps the result
// slot free; one level of compare logic and the state update lie between them.
// Reset: arst_n clears all decode state, loads default windows, command 0.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [irpfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irpfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// slave side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [irpfd_pkg::TIME_W-1:0]       s_tdata,  // [15:0] capture_time
	input  logic                               s_tuser,  // [0] opcode
	// master side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,  // [2:0] command_code, [7:3] zero
	output logic                               m_tlast,  // frame_done
	output logic                               m_tuser   // [0] frame_matched
);
	import irpfd_pkg::*;

	// Window registers
	logic [TIME_W-1:0] start_low_q, start_high_q;
	logic [TIME_W-1:0] one_low_q, one_high_q;
	logic [TIME_W-1:0] zero_low_q, zero_high_q;

	// Input stage
	logic              valid_s1;
	opcode_t           op_s1;
	logic [TIME_W-1:0] time_s1;

	// Decode state
	logic [TIME_W-1:0]     last_time_q, last_time_d;
	logic [WRAP_W-1:0]     wrap_q, wrap_d;
	logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
	logic [7:0]            shift_q, shift_d;
	logic [BYTE_IDX_W-1:0] byte_idx_q, byte_idx_d;
	logic [7:0]            frame_q [FRAME_BYTES];
	logic [7:0]            frame_d [FRAME_BYTES];
	cmd_t                  cmd_q, cmd_d;

	// Result stage
	logic       out_valid_q;
	logic [CMD_W-1:0] res_cmd_q;
	logic       res_done_q, res_match_q;
	logic       res_done, res_match;

	// Per-item datapath
	logic [TIME_W:0]   diff;
	logic [TIME_W-1:0] interval;
	logic              in_start, in_one, in_zero, byte_full;
	logic              advance;

	// Move the held item forward whenever the result slot frees up
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q  <= START_LOW_RST;
			start_high_q <= START_HIGH_RST;
			one_low_q    <= ONE_LOW_RST;
			one_high_q   <= ONE_HIGH_RST;
			zero_low_q   <= ZERO_LOW_RST;
			zero_high_q  <= ZERO_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_LOW:  start_low_q  <= cfg_data;
				REG_START_HIGH: start_high_q <= cfg_data;
				REG_ONE_LOW:    one_low_q    <= cfg_data;
				REG_ONE_HIGH:   one_high_q   <= cfg_data;
				REG_ZERO_LOW:   zero_low_q   <= cfg_data;
				REG_ZERO_HIGH:  zero_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= opcode_t'(s_tuser);
			time_s1 <= s_tdata;
		end
	end

	// Interval since last edge; one wrap with an earlier time still fits
	always_comb begin
		diff = {1'b0, time_s1} - {1'b0, last_time_q};
		if (wrap_q == '0 || (wrap_q == WRAP_W'(1) && diff[TIME_W])) begin
			interval = diff[TIME_W-1:0];
		end else begin
			interval = '1;
		end
		in_start = (interval > start_low_q) && (interval < start_high_q);
		in_one   = (interval > one_low_q)   && (interval < one_high_q);
		in_zero  = (interval > zero_low_q)  && (interval < zero_high_q);
	end

	// Next decode state and result for the held item
	always_comb begin
		last_time_d = last_time_q;
		wrap_d      = wrap_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		byte_idx_d  = byte_idx_q;
		frame_d     = frame_q;
		cmd_d       = cmd_q;
		res_done    = 1'b0;
		res_match   = 1'b0;
		byte_full   = 1'b0;

		if (op_s1 == OP_WRAP) begin
			// saturate the wrap count
			if (wrap_q != '1) begin
				wrap_d = wrap_q + WRAP_W'(1);
			end
		end else begin
			wrap_d      = '0;
			last_time_d = time_s1;

			// classify: start wins, then one, then zero
			if (in_start) begin
				bit_cnt_d  = '0;
				shift_d    = '0;
				byte_idx_d = '0;
			end else if (in_one) begin
				shift_d   = (shift_q >> 1) | ONE_BIT_MSB;
				bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
				byte_full = (bit_cnt_q == '1);
			end else if (in_zero) begin
				shift_d   = shift_q >> 1;
				bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
				byte_full = (bit_cnt_q == '1);
			end

			// store a finished byte, close the frame on the last one
			if (byte_full) begin
				frame_d[byte_idx_q] = shift_d;
				shift_d             = '0;
				bit_cnt_d           = '0;
				if (byte_idx_q == BYTE_IDX_W'(FRAME_BYTES - 1)) begin
					byte_idx_d = '0;
					res_done   = 1'b1;
					if (frame_d[0] == ADDR_LO && frame_d[1] == ADDR_HI) begin
						res_match = 1'b1;
						case ({frame_d[2], frame_d[3]})
							{PAIR_FWD_A,  PAIR_FWD_B}:  cmd_d = CMD_FWD;
							{PAIR_BACK_A, PAIR_BACK_B}: cmd_d = CMD_BACK;
							{PAIR_LEFT_A, PAIR_LEFT_B}: cmd_d = CMD_LEFT;
							{PAIR_RGT_A,  PAIR_RGT_B}:  cmd_d = CMD_RIGHT;
							{PAIR_CTR_A,  PAIR_CTR_B}:  cmd_d = CMD_CTR;
							default:                    cmd_d = cmd_q;
						endcase
						for (int i = 0; i < FRAME_BYTES; i++) begin
							frame_d[i] = '0;
						end
					end
				end else begin
					byte_idx_d = byte_idx_q + BYTE_IDX_W'(1);
				end
			end
		end
	end

	// Commit decode state as the item moves to the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			wrap_q      <= '0;
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			byte_idx_q  <= '0;
			cmd_q       <= CMD_NONE;
			for (int i = 0; i < FRAME_BYTES; i++) begin
				frame_q[i] <= '0;
			end
		end else if (advance) begin
			last_time_q <= last_time_d;
			wrap_q      <= wrap_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			byte_idx_q  <= byte_idx_d;
			cmd_q       <= cmd_d;
			frame_q     <= frame_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_cmd_q   <= cmd_d;
			res_done_q  <= res_done;
			res_match_q <= res_match;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8 - CMD_W){1'b0}}, res_cmd_q};
	assign m_tlast  = res_done_q;
	assign m_tuser  = res_match_q;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the IR pulse frame decoder
// Drives edge captures and timer wraps through the slave stream, predicts each
// result item with a local decoder model unless a typed table row carries it,
// and compares each result on the master stream field by field. Both stream sides
// idle at random; the timing windows are reloaded between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import irpfd_pkg::*;

	// Unused register indexes past the window registers; the block drops writes to them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int N_PHASES   = 9;
	localparam int PHASE_ITEMS = 1850 / N_PHASES;

	typedef struct packed {
		cmd_t cmd;
		logic done;
		logic matched;
	} decode_result_t;

	typedef struct packed {
		opcode_t        op;
		logic [15:0]    t;
		logic           typed;
		decode_result_t want;
	} pulse_row_t;

	localparam decode_result_t IDLE_RES = '{CMD_NONE, 1'b0, 1'b0};

	// Directed pulses under the reset windows; typed rows carry their result
	localparam int N_ROWS = 24;
	localparam pulse_row_t PULSE_TAB [N_ROWS] = '{
		'{OP_WRAP, 16'hFFFF, 1'b1, IDLE_RES},  // wrap right after reset
		'{OP_EDGE, 16'd0,    1'b1, IDLE_RES},  // one wrap, interval saturates
		'{OP_EDGE, 16'd65535, 1'b0, IDLE_RES}, // largest plain interval
		'{OP_EDGE, 16'd3999, 1'b0, IDLE_RES},  // earlier time, start low bound
		'{OP_EDGE, 16'd8000, 1'b0, IDLE_RES},  // start
		'{OP_EDGE, 16'd9799, 1'b0, IDLE_RES},  // one, just under the top
		'{OP_EDGE, 16'd11199, 1'b0, IDLE_RES}, // one low bound, ignored
		'{OP_EDGE, 16'd11600, 1'b0, IDLE_RES}, // zero, just over the bottom
		'{OP_EDGE, 16'd12299, 1'b0, IDLE_RES}, // zero, just under the top
		'{OP_EDGE, 16'd12999, 1'b0, IDLE_RES}, // zero high bound, ignored
		'{OP_EDGE, 16'd13400, 1'b0, IDLE_RES}, // zero
		'{OP_EDGE, 16'd14801, 1'b0, IDLE_RES}, // one
		'{OP_EDGE, 16'd19801, 1'b0, IDLE_RES}, // start high bound, ignored
		'{OP_WRAP, 16'h0000, 1'b1, IDLE_RES},
		'{OP_WRAP, 16'h5A5A, 1'b1, IDLE_RES},
		'{OP_WRAP, 16'hA5A5, 1'b1, IDLE_RES},
		'{OP_WRAP, 16'h1234, 1'b1, IDLE_RES},  // wrap count holds at three
		'{OP_EDGE, 16'd19801, 1'b0, IDLE_RES}, // many wraps, saturates
		'{OP_EDGE, 16'd65000, 1'b0, IDLE_RES},
		'{OP_WRAP, 16'hFFFF, 1'b1, IDLE_RES},
		'{OP_EDGE, 16'd100,  1'b0, IDLE_RES},  // zero across a wrap
		'{OP_EDGE, 16'd1501, 1'b0, IDLE_RES},  // one
		'{OP_EDGE, 16'd2000, 1'b0, IDLE_RES},  // zero, eighth bit ends a byte
		'{OP_EDGE, 16'd6001, 1'b0, IDLE_RES}   // start again
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [TIME_W-1:0]     s_tdata   = '0;  // [15:0] capture_time
	logic                  s_tuser   = 1'b0; // [0] opcode
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;         // [2:0] command_code, [7:3] zero
	logic                  m_tlast;         // frame_done
	logic                  m_tuser;         // [0] frame_matched

	// Decoder model state and window copy
	logic [15:0] win [6];
	logic [15:0] prev_edge;
	logic [1:0]  wraps;
	logic [3:0]  bits;
	logic [7:0]  shreg;
	logic [2:0]  byte_idx;
	logic [7:0]  fbytes [FRAME_BYTES];
	cmd_t        cur_cmd;

	decode_result_t pending_q [$];
	decode_result_t want;
	int             n_fail   = 0;
	int             item_cnt = 0;
	bit             tx_calm  = 1'b0;
	bit             rx_calm  = 1'b0;
	int             rx_stall = 0;

	ir_pulse_frame_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit in_span(input int unsigned v, input logic [15:0] lo,
			input logic [15:0] hi);
		return v > lo && v < hi;
	endfunction

	// Draw an interval strictly inside a window, or anything if it is empty
	function automatic int unsigned pick_in(input logic [15:0] lo, input logic [15:0] hi);
		int unsigned ilo, ihi;
		ilo = lo;
		ihi = hi;
		if (ihi > ilo + 1)
			return $urandom_range(ihi - 1, ilo + 1);
		return $urandom_range(65535, 0);
	endfunction

	function automatic logic [15:0] known_pair(input int k);
		case (k)
			0: return {PAIR_FWD_B, PAIR_FWD_A};
			1: return {PAIR_BACK_B, PAIR_BACK_A};
			2: return {PAIR_LEFT_B, PAIR_LEFT_A};
			3: return {PAIR_RGT_B, PAIR_RGT_A};
			default: return {PAIR_CTR_B, PAIR_CTR_A};
		endcase
	endfunction

	// Advance the decoder model by one item and form its result
	task automatic decode_item(input opcode_t op, input logic [15:0] now,
			output decode_result_t r);
		logic [15:0] diff;
		int unsigned span;
		r = IDLE_RES;
		if (op == OP_WRAP) begin
			if (wraps < 2'd3)
				wraps++;
		end else begin
			if (wraps == 2'd0) begin
				diff = now - prev_edge;
				span = diff;
			end else begin
				span = int'(now) + 32'h10000 * int'(wraps) - int'(prev_edge);
				if (span > 65535)
					span = 65535;
			end
			wraps = 2'd0;

			// classify: start wins, then one, then zero
			if (in_span(span, win[REG_START_LOW], win[REG_START_HIGH])) begin
				bits = '0;
				shreg = '0;
				byte_idx = '0;
			end else if (in_span(span, win[REG_ONE_LOW], win[REG_ONE_HIGH])) begin
				shreg = {1'b1, shreg[7:1]};
				bits++;
			end else if (in_span(span, win[REG_ZERO_LOW], win[REG_ZERO_HIGH])) begin
				shreg = {1'b0, shreg[7:1]};
				bits++;
			end

			// store a full byte, finish a frame
			if (bits >= 4'd8) begin
				if (byte_idx < FRAME_BYTES)
					fbytes[byte_idx[BYTE_IDX_W-1:0]] = shreg;
				byte_idx++;
				bits = '0;
				shreg = '0;
			end
			if (byte_idx >= FRAME_BYTES) begin
				byte_idx = '0;
				r.done = 1'b1;
				if (fbytes[0] == ADDR_LO && fbytes[1] == ADDR_HI) begin
					case ({fbytes[2], fbytes[3]})
						{PAIR_FWD_A, PAIR_FWD_B}:   cur_cmd = CMD_FWD;
						{PAIR_BACK_A, PAIR_BACK_B}: cur_cmd = CMD_BACK;
						{PAIR_LEFT_A, PAIR_LEFT_B}: cur_cmd = CMD_LEFT;
						{PAIR_RGT_A, PAIR_RGT_B}:   cur_cmd = CMD_RIGHT;
						{PAIR_CTR_A, PAIR_CTR_B}:   cur_cmd = CMD_CTR;
						default: ;
					endcase
					foreach (fbytes[k])
						fbytes[k] = '0;
					r.matched = 1'b1;
				end
			end
			prev_edge = now;
		end
		r.cmd = cur_cmd;
	endtask

	// Send one item after a random gap; predict it once accepted
	task automatic push_item(input opcode_t op, input logic [15:0] t,
			input logic typed = 1'b0, input decode_result_t fixed = '0);
		int gap;
		decode_result_t r;
		gap = tx_calm ? 0 : $urandom_range(15, 0);
		if ($urandom_range(63, 0) == 0)
			tx_calm = !tx_calm;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		decode_item(op, t, r);
		pending_q.push_back(typed ? fixed : r);
		item_cnt++;
	endtask

	// Emit an edge a given interval after the last one, with the wraps between
	task automatic emit_interval(input int unsigned span);
		longint unsigned target;
		int n;
		target = longint'(prev_edge) + span;
		n = int'(target >> 16);
		repeat (n) push_item(OP_WRAP, 16'($urandom));
		push_item(OP_EDGE, target[15:0]);
	endtask

	// Start pulse plus 32 bits, LSB first; a broken frame gets glitches
	task automatic send_frame(input logic [31:0] fw, input bit broken);
		emit_interval(pick_in(win[REG_START_LOW], win[REG_START_HIGH]));
		for (int i = 0; i < 32; i++) begin
			if (broken && $urandom_range(11, 0) == 0) begin
				case ($urandom_range(2, 0))
					0: emit_interval($urandom_range(65535, 0));
					1: push_item(OP_WRAP, 16'($urandom));
					default: emit_interval(pick_in(win[REG_START_LOW], win[REG_START_HIGH]));
				endcase
			end
			if (fw[i])
				emit_interval(pick_in(win[REG_ONE_LOW], win[REG_ONE_HIGH]));
			else
				emit_interval(pick_in(win[REG_ZERO_LOW], win[REG_ZERO_HIGH]));
		end
	endtask

	// Hold the sender until every result is back, then let the pipe drain
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx <= REG_ZERO_HIGH)
			win[idx] = val;
	endtask

	task automatic apply_windows(input logic [15:0] sl, input logic [15:0] sh,
			input logic [15:0] ol, input logic [15:0] oh,
			input logic [15:0] zl, input logic [15:0] zh);
		write_reg(REG_SPARE_A, 16'($urandom));
		write_reg(REG_START_LOW, sl);
		write_reg(REG_START_HIGH, sh);
		write_reg(REG_ONE_LOW, ol);
		write_reg(REG_ONE_HIGH, oh);
		write_reg(REG_ZERO_LOW, zl);
		write_reg(REG_ZERO_HIGH, zh);
		write_reg(REG_SPARE_B, 16'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result checker; also draws the receiver stall for the next item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$error("result item with nothing expected");
				n_fail++;
			end else begin
				want = pending_q.pop_front();
				if (m_tdata[2:0] !== want.cmd) begin
					$error("command_code: expected %0d, actual %0d", want.cmd, m_tdata[2:0]);
					n_fail++;
				end
				if (m_tlast !== want.done) begin
					$error("frame_done: expected %0d, actual %0d", want.done, m_tlast);
					n_fail++;
				end
				if (m_tuser !== want.matched) begin
					$error("frame_matched: expected %0d, actual %0d", want.matched, m_tuser);
					n_fail++;
				end
				if (m_tdata[7:3] !== 5'd0) begin
					$error("tdata pad: expected 0, actual %0d", m_tdata[7:3]);
					n_fail++;
				end
			end
			rx_stall = rx_calm ? 0 : $urandom_range(15, 0);
			if ($urandom_range(31, 0) == 0)
				rx_calm = !rx_calm;
		end
	end

	// Receiver ready: drop for the drawn stall, then hold high
	always @(negedge clk) begin
		if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall = rx_stall - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Stimulus
	initial begin
		int          phase_end;
		int          sel;
		int          pick;
		logic [31:0] fw;
		int unsigned zl, zh, ol, oh, sl, sh;

		win[REG_START_LOW]  = START_LOW_RST;
		win[REG_START_HIGH] = START_HIGH_RST;
		win[REG_ONE_LOW]    = ONE_LOW_RST;
		win[REG_ONE_HIGH]   = ONE_HIGH_RST;
		win[REG_ZERO_LOW]   = ZERO_LOW_RST;
		win[REG_ZERO_HIGH]  = ZERO_HIGH_RST;
		prev_edge = '0;
		wraps     = '0;
		bits      = '0;
		shreg     = '0;
		byte_idx  = '0;
		foreach (fbytes[k])
			fbytes[k] = '0;
		cur_cmd = CMD_NONE;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed pulses
		for (int i = 0; i < N_ROWS; i++)
			push_item(PULSE_TAB[i].op, PULSE_TAB[i].t, PULSE_TAB[i].typed, PULSE_TAB[i].want);

		// random phases; each phase after the first reloads the windows
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph != 0) begin
				settle();
				case (ph)
					1: apply_windows(16'd300, 16'd500, 16'd100, 16'd160, 16'd20, 16'd60);
					2: apply_windows(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
					3, 7: begin
						zl = $urandom_range(2000, 0);
						zh = zl + $urandom_range(2000, 2);
						ol = zh + $urandom_range(500, 0);
						oh = ol + $urandom_range(3000, 2);
						sl = oh + $urandom_range(500, 0);
						sh = sl + $urandom_range(8000, 2);
						apply_windows(16'(sl), 16'(sh), 16'(ol), 16'(oh), 16'(zl), 16'(zh));
					end
					// one window swallows the zero window
					4: apply_windows(16'd4000, 16'd5000, 16'd0, 16'hFFFF, 16'd400, 16'd700);
					5: apply_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
						16'hFFFF);
					// start window swallows everything
					6: apply_windows(16'd0, 16'hFFFF, 16'd1400, 16'd1800, 16'd400, 16'd700);
					default: apply_windows(START_LOW_RST, START_HIGH_RST, ONE_LOW_RST,
						ONE_HIGH_RST, ZERO_LOW_RST, ZERO_HIGH_RST);
				endcase
			end
			phase_end = item_cnt + PHASE_ITEMS;
			while (item_cnt < phase_end) begin
				sel = $urandom_range(99, 0);
				if (sel < 80) begin
					pick = $urandom_range(99, 0);
					if (pick < 55)
						fw = {known_pair($urandom_range(4, 0)), ADDR_HI, ADDR_LO};
					else if (pick < 70)
						fw = {16'($urandom), ADDR_HI, ADDR_LO};
					else if (pick < 85)
						fw = {known_pair($urandom_range(4, 0)), 16'($urandom)};
					else
						fw = $urandom;
					send_frame(fw, sel >= 65);
				end else begin
					// noise burst
					repeat ($urandom_range(8, 1)) begin
						case ($urandom_range(3, 0))
							0: push_item(OP_WRAP, 16'($urandom));
							1: push_item(OP_EDGE, 16'($urandom));
							2: emit_interval($urandom_range(300000, 0));
							default: emit_interval(pick_in(win[REG_ZERO_LOW], win[REG_ONE_HIGH]));
						endcase
					end
				end
			end
		end

		settle();
		if (n_fail == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/irpfd_pkg.sv
hw/rtl/ir_pulse_frame_decoder.sv
bench/testbench.sv
